// ===== rtl/core/lpbd_pkg.sv =====
`timescale 1ns / 1ps

package lpbd_pkg;

	localparam int NUM_BANDS = 8;
	localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
	localparam int THERM_W   = $clog2(NUM_BANDS + 1);

	localparam int THR_W     = 8;
	localparam int DIM_W     = 11;
	localparam int BWIDTH_W  = 9;
	localparam int CTR_W     = 10;
	localparam int SPEED_W   = 7;
	localparam int SERVO_W   = 8;
	localparam int PCT_W     = 7;
	localparam int POS_W     = 14;
	localparam int COUNT_W   = 18;

	// edges of the bands: k*band_width for k up to NUM_BANDS
	localparam int MULT_W    = $clog2(NUM_BANDS * 256 + 1);
	localparam int CMP_W     = (MULT_W > CTR_W) ? MULT_W : CTR_W;

	// percentage arithmetic
	localparam int DEN_W     = 19;
	localparam int NUM_W     = 25;
	localparam int DIV_W     = 26;
	localparam int STEP_W    = 3;
	localparam logic [STEP_W-1:0] TOP_STEP = STEP_W'(PCT_W - 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);
	localparam logic [SERVO_W-1:0] SERVO_LEFT     = SERVO_W'(30);
	localparam logic [SERVO_W-1:0] SERVO_STRAIGHT = SERVO_W'(90);
	localparam logic [SERVO_W-1:0] SERVO_RIGHT    = SERVO_W'(150);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST      = 3'd6;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [THR_W-1:0]    value_threshold;
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic [BWIDTH_W-1:0] band_width;
		logic [CTR_W-1:0]    center_position;
		logic [SPEED_W-1:0]  slow_speed;
		logic [SPEED_W-1:0]  fast_speed;
	} cfg_t;

	// one classified pixel
	typedef struct packed {
		logic              sof;
		logic              hit;
		logic [BAND_W-1:0] band;
		logic              frame_end;
	} word_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (v > DIM_W'(1024)) r = DIM_W'(1024);
		return r;
	endfunction

	function automatic logic [BWIDTH_W-1:0] clamp_band(input logic [BWIDTH_W-1:0] v);
		logic [BWIDTH_W-1:0] r;
		r = v;
		if (v == '0) r = BWIDTH_W'(1);
		else if (v > BWIDTH_W'(256)) r = BWIDTH_W'(256);
		return r;
	endfunction

endpackage

// ===== rtl/core/lpbd_front.sv =====
`timescale 1ns / 1ps

module lpbd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpbd_pkg::THR_W-1:0]  blue,
	input  logic [lpbd_pkg::THR_W-1:0]  green,
	input  logic [lpbd_pkg::THR_W-1:0]  red,
	input  logic                        start_of_frame,
	input  lpbd_pkg::cfg_t              cfg,
	input  logic                        q_full,
	output logic                        busy,
	output logic                        push,
	output lpbd_pkg::word_t             word
);
	import lpbd_pkg::*;

	logic [CTR_W-1:0]    col_q, row_q, col, row, w_m1, h_m1;
	logic [DIM_W-1:0]    wc, hc;
	logic [BWIDTH_W-1:0] bwc;
	logic [THR_W-1:0]    mx;
	logic [NUM_BANDS-1:0] past_edge;
	logic [THERM_W-1:0]  band_cnt;
	logic                row_end, frame_end;

	always_comb begin
		wc   = clamp_dim(cfg.image_width);
		hc   = clamp_dim(cfg.image_height);
		bwc  = clamp_band(cfg.band_width);
		w_m1 = CTR_W'(wc - DIM_W'(1));
		h_m1 = CTR_W'(hc - DIM_W'(1));
		col  = start_of_frame ? '0 : col_q;
		row  = start_of_frame ? '0 : row_q;

		mx = blue;
		if (green > mx) mx = green;
		if (red > mx) mx = red;

		// thermometer of band edges passed, its count is the band index
		band_cnt = '0;
		for (int k = 0; k < NUM_BANDS; k++) begin
			past_edge[k] = CMP_W'(col) >= CMP_W'(k + 1) * CMP_W'(bwc);
			band_cnt = band_cnt + THERM_W'(past_edge[k]);
		end

		row_end   = col >= w_m1;
		frame_end = row_end && (row >= h_m1);

		busy = q_full;
		push = start && !q_full;
		word.sof       = start_of_frame;
		word.hit       = (mx <= cfg.value_threshold) && !past_edge[NUM_BANDS-1];
		word.band      = BAND_W'(band_cnt);
		word.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row + CTR_W'(1);
			end else begin
				col_q <= col + CTR_W'(1);
				row_q <= row;
			end
		end
	end

endmodule

// ===== rtl/core/lpbd_queue.sv =====
`timescale 1ns / 1ps

module lpbd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpbd_pkg::word_t din,
	input  logic            pop,
	output lpbd_pkg::word_t dout,
	output logic            full,
	output logic            empty
);
	import lpbd_pkg::*;

	word_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("word pushed into full queue");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
		else $error("queue fill count lost a pop");

endmodule

// ===== rtl/core/lpbd_back.sv =====
`timescale 1ns / 1ps

module lpbd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpbd_pkg::cfg_t                cfg,
	input  logic                          q_empty,
	input  lpbd_pkg::word_t               head,
	output logic                          pop,
	output logic                          done,
	output logic [5:0]                    best_band,
	output logic [lpbd_pkg::PCT_W-1:0]    best_percent,
	output logic [lpbd_pkg::POS_W-1:0]    line_position,
	output logic [lpbd_pkg::SPEED_W-1:0]  left_speed,
	output logic [lpbd_pkg::SPEED_W-1:0]  right_speed,
	output logic [lpbd_pkg::SERVO_W-1:0]  servo_angle
);
	import lpbd_pkg::*;

	typedef enum logic [2:0] {
		ST_RUN, ST_DEN, ST_DEN101, ST_CHECK, ST_DIV, ST_POS, ST_EMIT
	} state_t;

	state_t            state_q;
	logic [COUNT_W-1:0] counts_q [NUM_BANDS];
	logic [DEN_W-1:0]  den_q;
	logic [DIV_W-1:0]  den101_q;
	logic [BAND_W-1:0] idx_q, best_q;
	logic [PCT_W-1:0]  best_pct_q, quo_q;
	logic [NUM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  pos_q;

	logic [BWIDTH_W-1:0] bwc;
	logic [DIM_W-1:0]    hc;
	logic [NUM_W-1:0]    num;
	logic [DIV_W-1:0]    trial;
	logic                ge;
	logic [PCT_W-1:0]    quo_next;
	logic                last_band;

	always_comb begin
		bwc       = clamp_band(cfg.band_width);
		hc        = clamp_dim(cfg.image_height);
		pop       = (state_q == ST_RUN) && !q_empty;
		num       = NUM_W'(counts_q[idx_q]) * NUM_W'(100);
		trial     = DIV_W'(den_q) << step_q;
		ge        = DIV_W'(rem_q) >= trial;
		quo_next  = quo_q | (PCT_W'(ge) << step_q);
		last_band = idx_q == BAND_W'(NUM_BANDS - 1);
	end

	// band counters, cleared at frame start and after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANDS; i++) counts_q[i] <= '0;
		end else if (pop) begin
			for (int i = 0; i < NUM_BANDS; i++) begin
				if (head.sof) begin
					counts_q[i] <= (head.hit && head.band == BAND_W'(i)) ?
						COUNT_W'(1) : '0;
				end else if (head.hit && head.band == BAND_W'(i) &&
						counts_q[i] != COUNT_MAX) begin
					counts_q[i] <= counts_q[i] + COUNT_W'(1);
				end
			end
		end else if (state_q == ST_EMIT) begin
			for (int i = 0; i < NUM_BANDS; i++) counts_q[i] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_RUN;
			done          <= 1'b0;
			idx_q         <= '0;
			best_q        <= '0;
			best_pct_q    <= '0;
			quo_q         <= '0;
			step_q        <= '0;
			best_band     <= '0;
			best_percent  <= '0;
			line_position <= '0;
			left_speed    <= '0;
			right_speed   <= '0;
			servo_angle   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_RUN: begin
					if (pop && head.frame_end) state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q      <= DEN_W'(DEN_W'(bwc) * DEN_W'(hc));
					idx_q      <= '0;
					best_q     <= '0;
					best_pct_q <= '0;
					state_q    <= ST_DEN101;
				end
				ST_DEN101: begin
					den101_q <= DIV_W'(den_q) * DIV_W'(101);
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					if (DIV_W'(num) >= den101_q) begin
						// quotient past 100, clamp
						if (PCT_FULL > best_pct_q) begin
							best_pct_q <= PCT_FULL;
							best_q     <= idx_q;
						end
						idx_q   <= idx_q + BAND_W'(1);
						state_q <= last_band ? ST_POS : ST_CHECK;
					end else begin
						rem_q   <= num;
						quo_q   <= '0;
						step_q  <= TOP_STEP;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (ge) rem_q <= NUM_W'(DIV_W'(rem_q) - trial);
					quo_q <= quo_next;
					if (step_q == '0) begin
						if (quo_next > best_pct_q) begin
							best_pct_q <= quo_next;
							best_q     <= idx_q;
						end
						idx_q   <= idx_q + BAND_W'(1);
						state_q <= last_band ? ST_POS : ST_CHECK;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_POS: begin
					pos_q   <= POS_W'(POS_W'(best_q) * POS_W'(bwc) + POS_W'(bwc >> 1));
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					done          <= 1'b1;
					best_band     <= 6'(best_q);
					best_percent  <= best_pct_q;
					line_position <= pos_q;
					if (pos_q < POS_W'(cfg.center_position)) begin
						left_speed  <= cfg.slow_speed;
						right_speed <= cfg.fast_speed;
						servo_angle <= SERVO_LEFT;
					end else if (pos_q > POS_W'(cfg.center_position)) begin
						left_speed  <= cfg.fast_speed;
						right_speed <= cfg.slow_speed;
						servo_angle <= SERVO_RIGHT;
					end else begin
						left_speed  <= cfg.fast_speed;
						right_speed <= cfg.fast_speed;
						servo_angle <= SERVO_STRAIGHT;
					end
					state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EMIT)) else $error("result word outside emit");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> best_percent <= PCT_FULL) else $error("percentage above 100");
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> state_q != ST_DIV)
		else $error("divider ran past last step");

endmodule

// ===== rtl/core/line_position_band_detector_unit.sv =====
`timescale 1ns / 1ps

// line position band detector: takes one BGR pixel word per clock (start high,
// busy low) in raster order and counts dark pixels (max of B, G, R at most the
// value threshold) per vertical band. on the last pixel of a frame the back end
// scans the bands: it forms the denominator (ST_DEN, ST_DEN101), then per band
// clamps the percentage to 100 in ST_CHECK or runs a bit-serial divider in
// ST_DIV, then forms position and steering (ST_POS, ST_EMIT). the frame-end
// word passes through the queue first, so the result word comes later when
// earlier words still wait in the queue.
// done is high for exactly one cycle with the result; the receiver cannot
// stall it. pixels keep arriving during the scan into a four-word queue, and
// busy rises only when that queue is full, so the scan fits in line blanking.
// the user must write configuration through cfg_we/cfg_index/cfg_data only
// while no frame result is pending; the block itself does not enforce this.
// unused indexes are ignored

module line_position_band_detector_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel words
	input  logic                              start,
	output logic                              busy,
	input  logic [lpbd_pkg::THR_W-1:0]        blue,
	input  logic [lpbd_pkg::THR_W-1:0]        green,
	input  logic [lpbd_pkg::THR_W-1:0]        red,
	input  logic                              start_of_frame,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [lpbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// result words
	output logic                              done,
	output logic [5:0]                        best_band,
	output logic [lpbd_pkg::PCT_W-1:0]        best_percent,
	output logic [lpbd_pkg::POS_W-1:0]        line_position,
	output logic [lpbd_pkg::SPEED_W-1:0]      left_speed,
	output logic [lpbd_pkg::SPEED_W-1:0]      right_speed,
	output logic [lpbd_pkg::SERVO_W-1:0]      servo_angle
);
	import lpbd_pkg::*;

	cfg_t  cfg_q;
	word_t front_word, head;
	logic  push, pop, q_full, q_empty;

	// configuration registers, reset to the default camera setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.value_threshold <= THR_W'(50);
			cfg_q.image_width     <= DIM_W'(320);
			cfg_q.image_height    <= DIM_W'(240);
			cfg_q.band_width      <= BWIDTH_W'(40);
			cfg_q.center_position <= CTR_W'(160);
			cfg_q.slow_speed      <= SPEED_W'(50);
			cfg_q.fast_speed      <= SPEED_W'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.value_threshold <= cfg_data[THR_W-1:0];
				CFG_WIDTH:     cfg_q.image_width     <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:    cfg_q.image_height    <= cfg_data[DIM_W-1:0];
				CFG_BAND:      cfg_q.band_width      <= cfg_data[BWIDTH_W-1:0];
				CFG_CENTER:    cfg_q.center_position <= cfg_data[CTR_W-1:0];
				CFG_SLOW:      cfg_q.slow_speed      <= cfg_data[SPEED_W-1:0];
				CFG_FAST:      cfg_q.fast_speed      <= cfg_data[SPEED_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// front: raster counters, dark test and band lookup
	lpbd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.cfg            (cfg_q),
		.q_full         (q_full),
		.busy           (busy),
		.push           (push),
		.word           (front_word)
	);

	// short queue so the front keeps taking pixels during the band scan
	lpbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_word),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: band counters, percentage scan and steering decision
	lpbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.done          (done),
		.best_band     (best_band),
		.best_percent  (best_percent),
		.line_position (line_position),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.servo_angle   (servo_angle)
	);

endmodule

// ===== verif/line_position_band_detector_unit_tb.sv =====
`timescale 1ns / 1ps

module line_position_band_detector_unit_tb;
	import lpbd_pkg::*;

	// quiet time before a register write: the band scan after a frame end plus
	// the pixel queue, with margin
	localparam int SETTLE_CYCLES  = 100;
	// cycles with no word moving on either side before the run is called hung
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_CAP      = 100;
	// pixel words sent over the whole run, random frames fill up to this
	localparam int ITEM_GOAL      = 750;
	localparam int unsigned TALLY_MAX = 262143;
	// index outside the register map, must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	// one expected result word
	typedef struct packed {
		logic [5:0]         band;
		logic [PCT_W-1:0]   percent;
		logic [POS_W-1:0]   position;
		logic [SPEED_W-1:0] left;
		logic [SPEED_W-1:0] right;
		logic [SERVO_W-1:0] servo;
	} steer_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [THR_W-1:0]      blue;
	logic [THR_W-1:0]      green;
	logic [THR_W-1:0]      red;
	logic                  start_of_frame;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	logic [5:0]            best_band;
	logic [PCT_W-1:0]      best_percent;
	logic [POS_W-1:0]      line_position;
	logic [SPEED_W-1:0]    left_speed;
	logic [SPEED_W-1:0]    right_speed;
	logic [SERVO_W-1:0]    servo_angle;

	line_position_band_detector_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.best_band      (best_band),
		.best_percent   (best_percent),
		.line_position  (line_position),
		.left_speed     (left_speed),
		.right_speed    (right_speed),
		.servo_angle    (servo_angle)
	);

	always #5 clk = ~clk;

	// shadow of the register file, starting at the reset values
	logic [THR_W-1:0]    thr_reg    = 8'd50;
	logic [DIM_W-1:0]    width_reg  = 11'd320;
	logic [DIM_W-1:0]    height_reg = 11'd240;
	logic [BWIDTH_W-1:0] bandw_reg  = 9'd40;
	logic [CTR_W-1:0]    center_reg = 10'd160;
	logic [SPEED_W-1:0]  slow_reg   = 7'd50;
	logic [SPEED_W-1:0]  fast_reg   = 7'd100;

	// shadow of the frame state
	int unsigned dark_tally [NUM_BANDS];
	logic [9:0]  col_pos = '0;
	logic [9:0]  row_pos = '0;

	steer_word_t steering_due [$];
	steer_word_t oldest_due;

	int mismatch_count = 0;
	int pixels_sent    = 0;
	int results_seen   = 0;
	int cfg_writes     = 0;
	int burst_left     = 0;
	int idle_cycles    = 0;

	function automatic int unsigned bounded(input int unsigned v, lo, hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got, want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic clear_tally();
		foreach (dark_tally[i]) dark_tally[i] = 0;
		col_pos = '0;
		row_pos = '0;
	endtask

	// advance the shadow by one accepted pixel word, queue a result word on frame end
	task automatic track_pixel(input logic [7:0] b, g, r, input logic sof);
		int unsigned w, h, bw, peak, band, denom, pct, best, best_pct, pos;
		bit frame_end;
		steer_word_t res;
		w = bounded(width_reg, 1, 1024);
		h = bounded(height_reg, 1, 1024);
		bw = bounded(bandw_reg, 1, 256);
		frame_end = 1'b0;
		if (sof) clear_tally();
		peak = b;
		if (g > peak) peak = g;
		if (r > peak) peak = r;
		// columns past the last band fall out here
		band = col_pos / bw;
		if (peak <= thr_reg && band < NUM_BANDS) begin
			if (dark_tally[band] < TALLY_MAX) dark_tally[band]++;
		end
		if (col_pos >= w - 1) begin
			col_pos = '0;
			if (row_pos >= h - 1) frame_end = 1'b1;
			else row_pos = row_pos + 10'd1;
		end else begin
			col_pos = col_pos + 10'd1;
		end
		if (frame_end) begin
			denom = bw * h;
			best = 0;
			best_pct = 0;
			// strictly greater, so the first of equal bands wins
			for (int i = 0; i < NUM_BANDS; i++) begin
				pct = (dark_tally[i] * 100) / denom;
				if (pct > 100) pct = 100;
				if (pct > best_pct) begin
					best_pct = pct;
					best = i;
				end
			end
			pos = best * bw + bw / 2;
			res.band = 6'(best);
			res.percent = PCT_W'(best_pct);
			res.position = POS_W'(pos);
			if (pos < center_reg) begin
				res.left = slow_reg;
				res.right = fast_reg;
				res.servo = SERVO_LEFT;
			end else if (pos > center_reg) begin
				res.left = fast_reg;
				res.right = slow_reg;
				res.servo = SERVO_RIGHT;
			end else begin
				res.left = fast_reg;
				res.right = fast_reg;
				res.servo = SERVO_STRAIGHT;
			end
			steering_due.push_back(res);
			clear_tally();
		end
	endtask

	// one pixel word through the start/busy handshake, bursts with random gaps
	task automatic push_pixel(input logic [7:0] b, g, r, input logic sof);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
		end
		@(negedge clk);
		start = 1'b1;
		blue = b;
		green = g;
		red = r;
		start_of_frame = sof;
		do @(posedge clk); while (busy);
		burst_left--;
		pixels_sent++;
		track_pixel(b, g, r, sof);
	endtask

	// stop sending, let every pending result word come back, then let the scan drain
	task automatic settle_idle();
		@(negedge clk);
		start = 1'b0;
		while (steering_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		settle_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		cfg_writes++;
		case (idx)
			CFG_THRESHOLD: thr_reg = value[THR_W-1:0];
			CFG_WIDTH:     width_reg = value[DIM_W-1:0];
			CFG_HEIGHT:    height_reg = value[DIM_W-1:0];
			CFG_BAND:      bandw_reg = value[BWIDTH_W-1:0];
			CFG_CENTER:    center_reg = value[CTR_W-1:0];
			CFG_SLOW:      slow_reg = value[SPEED_W-1:0];
			CFG_FAST:      fast_reg = value[SPEED_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] thr, w, h, bw, ctr, slow, fast);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_BAND, bw);
		write_reg(CFG_CENTER, ctr);
		write_reg(CFG_SLOW, slow);
		write_reg(CFG_FAST, fast);
	endtask

	// random pixel on the chosen side of the current threshold
	function automatic logic [23:0] shade_pixel(input bit dark);
		logic [7:0] ch [0:2];
		int unsigned k;
		for (int i = 0; i < 3; i++)
			ch[i] = dark ? 8'($urandom_range(0, thr_reg)) : 8'($urandom_range(0, 255));
		if (!dark && thr_reg != 8'hFF) begin
			k = $urandom_range(0, 2);
			ch[k] = 8'($urandom_range(thr_reg + 1, 255));
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	// raster frame with a dark stripe over columns lo..hi (none when lo > hi)
	task automatic send_frame(input int cols, rows, lo, hi, in_pct, out_pct, input bit mark_sof);
		logic [23:0] px;
		bit dark;
		for (int y = 0; y < rows; y++) begin
			for (int x = 0; x < cols; x++) begin
				dark = (x >= lo && x <= hi) ? ($urandom_range(1, 100) <= in_pct)
					: ($urandom_range(1, 100) <= out_pct);
				px = shade_pixel(dark);
				push_pixel(px[23:16], px[15:8], px[7:0], mark_sof && x == 0 && y == 0);
			end
		end
	endtask

	// unstructured words with stray start-of-frame marks
	task automatic send_noise(input int count);
		logic [23:0] px;
		repeat (count) begin
			px = shade_pixel(1'($urandom_range(0, 1)));
			push_pixel(px[23:16], px[15:8], px[7:0], $urandom_range(0, 9) == 0);
		end
	endtask

	// ---------------------------------------------------------------- tests

	// only the height is shortened, so threshold, width, band width, centre and
	// speeds are the values out of reset
	task automatic test_reset_values();
		write_reg(CFG_HEIGHT, 11'd1);
		send_frame(320, 1, 120, 159, 100, 0, 1'b1);  // band 3, left of centre
	endtask

	// left, straight, right and the empty frame
	task automatic test_steering();
		load_settings(11'd50, 11'd24, 11'd1, 11'd4, 11'd10, 11'd0, 11'd127);
		write_reg(CFG_UNUSED, 11'h7FF);
		send_frame(24, 1, 8, 11, 100, 0, 1'b1);   // position equals centre
		send_frame(24, 1, 0, 3, 100, 0, 1'b1);
		send_frame(24, 1, 20, 23, 100, 0, 1'b0);
		send_frame(24, 1, 1, 0, 0, 0, 1'b1);      // no dark pixel at all
	endtask

	// ties go to the lowest band; centre at zero
	task automatic test_first_max();
		load_settings(11'd128, 11'd16, 11'd2, 11'd2, 11'd0, 11'd100, 11'd127);
		send_frame(16, 2, 2, 11, 100, 0, 1'b1);
		send_frame(16, 2, 6, 9, 100, 50, 1'b1);
	endtask

	// threshold at both ends, single-column bands
	task automatic test_threshold_extremes();
		load_settings(11'd0, 11'd8, 11'd1, 11'd1, 11'd3, 11'd100, 11'd0);
		push_pixel(8'h01, 8'h00, 8'h00, 1'b1);
		push_pixel(8'h00, 8'h01, 8'h00, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h01, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		push_pixel(8'h80, 8'h00, 8'h00, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		push_pixel(8'h7F, 8'hFE, 8'h00, 1'b0);
		write_reg(CFG_THRESHOLD, 11'd255);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_pixel(8'hAA, 8'h55, 8'hFF, 1'b0);
		push_pixel(8'h55, 8'hAA, 8'h00, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'hAA, 1'b0);
		send_frame(4, 1, 0, 3, 100, 0, 1'b0);
	endtask

	// start of frame in the middle of a frame throws the partial counts away
	task automatic test_start_of_frame();
		load_settings(11'd50, 11'd10, 11'd3, 11'd2, 11'd5, 11'd30, 11'd60);
		send_frame(10, 1, 0, 9, 100, 0, 1'b1);
		send_frame(3, 1, 0, 2, 100, 0, 1'b0);
		send_frame(10, 3, 6, 7, 100, 0, 1'b1);
		// back to back with no start mark
		send_frame(10, 3, 0, 1, 100, 0, 1'b0);
	endtask

	// zero and oversized sizes, columns past the last band
	task automatic test_size_clamps();
		// every pixel is a frame of its own
		load_settings(11'd100, 11'd0, 11'd0, 11'd0, 11'd0, 11'd1, 11'd2);
		send_noise(4);
		// band width above 256 clamps, one band centred at 128
		load_settings(11'd60, 11'd20, 11'd1, 11'd511, 11'd1023, 11'd5, 11'd6);
		send_frame(20, 1, 3, 9, 100, 0, 1'b1);
		// only columns 0..7 are in a band, the line sits beyond them
		load_settings(11'd60, 11'd20, 11'd1, 11'd1, 11'd7, 11'd9, 11'd99);
		send_frame(20, 1, 10, 19, 100, 0, 1'b1);
	endtask

	// height shrunk under a partial frame pushes the percentage over 100
	task automatic test_percent_clamp();
		load_settings(11'd255, 11'd2, 11'd8, 11'd2, 11'd1, 11'd11, 11'd22);
		send_frame(2, 6, 0, 1, 100, 0, 1'b1);
		write_reg(CFG_HEIGHT, 11'd1);
		send_frame(2, 1, 0, 1, 100, 0, 1'b0);
	endtask

	// mostly well-formed small frames with random content, some noise and pauses
	task automatic test_random_frames();
		int result_goal, frames, kind, cols, rows, bw, lo;
		logic [CFG_DATA_W-1:0] thr, w, h, bwr, ctr;
		result_goal = results_seen + 8;
		while (pixels_sent < ITEM_GOAL || results_seen < result_goal) begin
			case ($urandom_range(0, 9))
				0:       thr = 11'd0;
				1:       thr = 11'd255;
				default: thr = 11'($urandom_range(0, 255));
			endcase
			w = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 16));
			h = 11'($urandom_range(0, 3));
			bwr = 11'($urandom_range(0, 6));
			ctr = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
				: 11'($urandom_range(0, 30));
			load_settings(thr, w, h, bwr, ctr, 11'($urandom_range(0, 127)),
				11'($urandom_range(0, 127)));
			cols = bounded(w, 1, 1024);
			rows = bounded(h, 1, 1024);
			bw = bounded(bwr, 1, 256);
			frames = $urandom_range(1, 4);
			repeat (frames) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					lo = $urandom_range(0, cols - 1);
					send_frame(cols, rows, lo, lo + $urandom_range(0, 2 * bw),
						$urandom_range(60, 100), $urandom_range(0, 30),
						1'($urandom_range(0, 1)));
				end else if (kind < 9) begin
					send_noise($urandom_range(1, 2 * cols * rows));
				end else begin
					settle_idle();
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- checking

	// every result word against the oldest pending frame
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (steering_due.size() == 0) begin
				flag_mismatch("result word with no frame pending", 0, 0);
			end else begin
				oldest_due = steering_due.pop_front();
				if (best_band !== oldest_due.band)
					flag_mismatch("best_band", best_band, oldest_due.band);
				if (best_percent !== oldest_due.percent)
					flag_mismatch("best_percent", best_percent, oldest_due.percent);
				if (line_position !== oldest_due.position)
					flag_mismatch("line_position", line_position, oldest_due.position);
				if (left_speed !== oldest_due.left)
					flag_mismatch("left_speed", left_speed, oldest_due.left);
				if (right_speed !== oldest_due.right)
					flag_mismatch("right_speed", right_speed, oldest_due.right);
				if (servo_angle !== oldest_due.servo)
					flag_mismatch("servo_angle", servo_angle, oldest_due.servo);
			end
		end
	end

	// hang detection: no word taken and no result for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without progress, %0d results pending",
				idle_cycles, steering_due.size());
			$display("FAIL line_position_band_detector_unit");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		blue = '0;
		green = '0;
		red = '0;
		start_of_frame = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		clear_tally();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_steering();
		test_first_max();
		test_threshold_extremes();
		test_start_of_frame();
		test_size_clamps();
		test_percent_clamp();
		test_random_frames();

		// drain: all frames answered, then room for a stray late word
		settle_idle();

		$display("covered %0d pixel words, %0d frame results, %0d register writes",
			pixels_sent, results_seen, cfg_writes);
		$display("steering cases, threshold edges, size and percent clamps, random frames; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS line_position_band_detector_unit");
		end else begin
			$display("FAIL line_position_band_detector_unit");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lpbd_pkg.sv
rtl/core/lpbd_front.sv
rtl/core/lpbd_queue.sv
rtl/core/lpbd_back.sv
rtl/core/line_position_band_detector_unit.sv
verif/line_position_band_detector_unit_tb.sv
